/* hw/rtl/dthf_pkg.sv */
package dthf_pkg;

  localparam int unsigned InBits   = 64;
  localparam int unsigned FracBits = 52;
  localparam int unsigned ExpBits  = 11;
  localparam int unsigned PowBits  = 12;
  localparam int unsigned MagBits  = 11;
  localparam int unsigned DigCount = 4;
  localparam int unsigned DigIdxW  = 2;
  localparam int unsigned CharBits = 7;
  localparam int unsigned OutBytes = 8;
  localparam int unsigned ProdBits = 14;

  localparam logic [ExpBits-1:0] ExpBias = 11'd1023;
  localparam logic [ExpBits-1:0] ExpOnes = 11'h7ff;
  localparam logic [PowBits-1:0] SubPow  = -12'sd1022;

  localparam logic [ProdBits-1:0] Place [DigCount] = '{14'd1, 14'd10, 14'd100, 14'd1000};

  localparam logic [CharBits-1:0] ChMinus = 7'h2d;
  localparam logic [CharBits-1:0] ChPlus  = 7'h2b;
  localparam logic [CharBits-1:0] ChZero  = 7'h30;
  localparam logic [CharBits-1:0] ChOne   = 7'h31;
  localparam logic [CharBits-1:0] ChX     = 7'h78;
  localparam logic [CharBits-1:0] ChDot   = 7'h2e;
  localparam logic [CharBits-1:0] ChP     = 7'h70;
  localparam logic [CharBits-1:0] ChHexA  = 7'h57;
  localparam logic [CharBits-1:0] ChNul   = 7'h00;

  typedef enum logic [3:0] {
    SEL_MINUS,
    SEL_ZERO,
    SEL_X,
    SEL_LEAD,
    SEL_DOT,
    SEL_NIB,
    SEL_P,
    SEL_ESGN,
    SEL_DIG,
    SEL_NUL
  } sel_e;

  typedef struct packed {
    logic               load;
    logic               shift_norm;
    logic               mag_load;
    logic               conv;
    logic [DigIdxW-1:0] conv_place;
    logic               emit;
    sel_e               sel;
    logic               last;
    logic               invalid;
    logic [DigIdxW-1:0] dig_idx;
  } cmd_t;

  typedef struct packed {
    logic               neg;
    logic               is_inf;
    logic               is_short;
    logic               norm_done;
    logic               frac_nz;
    logic               nib_last;
    logic               out_free;
    logic [DigIdxW-1:0] top_dig;
  } stat_t;

endpackage

/* hw/rtl/dthf_ctrl.sv */
module dthf_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  dthf_pkg::stat_t      stat_i,
  output dthf_pkg::cmd_t       cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NORM,
    ST_CONV,
    ST_SIGN,
    ST_LEAD0,
    ST_LEADX,
    ST_LEAD1,
    ST_DOT,
    ST_NIB,
    ST_P,
    ST_ESGN,
    ST_DIG,
    ST_INV
  } state_e;

  state_e                        state_q, state_d;
  logic [dthf_pkg::DigIdxW-1:0]  place_q, place_d;
  logic [dthf_pkg::DigIdxW-1:0]  idx_q, idx_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    place_d = place_q;
    idx_d   = idx_q;
    cmd_o   = '0;
    cmd_o.sel        = dthf_pkg::SEL_NUL;
    cmd_o.conv_place = place_q;
    cmd_o.dig_idx    = idx_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_NORM;
        end
      end
      ST_NORM: begin
        if (stat_i.is_inf) begin
          state_d = ST_INV;
        end else if (stat_i.norm_done) begin
          cmd_o.mag_load = 1'b1;
          place_d        = '1;
          state_d        = ST_CONV;
        end else begin
          cmd_o.shift_norm = 1'b1;
        end
      end
      ST_CONV: begin
        cmd_o.conv = 1'b1;
        if (place_q == '0) begin
          state_d = stat_i.neg ? ST_SIGN : ST_LEAD0;
        end else begin
          place_d = place_q - 1'b1;
        end
      end
      ST_SIGN: begin
        cmd_o.sel = dthf_pkg::SEL_MINUS;
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_LEAD0;
        end
      end
      ST_LEAD0: begin
        cmd_o.sel = dthf_pkg::SEL_ZERO;
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_LEADX;
        end
      end
      ST_LEADX: begin
        cmd_o.sel = dthf_pkg::SEL_X;
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_LEAD1;
        end
      end
      ST_LEAD1: begin
        cmd_o.sel = dthf_pkg::SEL_LEAD;
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = stat_i.is_short ? ST_P : ST_DOT;
        end
      end
      ST_DOT: begin
        cmd_o.sel = dthf_pkg::SEL_DOT;
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = stat_i.frac_nz ? ST_NIB : ST_P;
        end
      end
      ST_NIB: begin
        cmd_o.sel = dthf_pkg::SEL_NIB;
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (stat_i.nib_last) begin
            state_d = ST_P;
          end
        end
      end
      ST_P: begin
        cmd_o.sel = dthf_pkg::SEL_P;
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_ESGN;
        end
      end
      ST_ESGN: begin
        cmd_o.sel = dthf_pkg::SEL_ESGN;
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          idx_d      = stat_i.top_dig;
          state_d    = ST_DIG;
        end
      end
      ST_DIG: begin
        cmd_o.sel  = dthf_pkg::SEL_DIG;
        cmd_o.last = (idx_q == '0);
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (idx_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            idx_d = idx_q - 1'b1;
          end
        end
      end
      ST_INV: begin
        cmd_o.sel     = dthf_pkg::SEL_NUL;
        cmd_o.last    = 1'b1;
        cmd_o.invalid = 1'b1;
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      place_q <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      place_q <= place_d;
      idx_q   <= idx_d;
    end
  end

endmodule

/* hw/rtl/dthf_dp.sv */
module dthf_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [dthf_pkg::InBits-1:0]      in_bits_i,
  input  dthf_pkg::cmd_t                   cmd_i,
  output dthf_pkg::stat_t                  stat_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [dthf_pkg::CharBits-1:0]    out_char_o,
  output logic                             out_last_o,
  output logic                             out_invalid_o
);

  logic                              neg_q;
  logic                              inf_q;
  logic                              zero_q;
  logic                              short_q;
  logic [dthf_pkg::FracBits:0]       frac_q;
  logic [dthf_pkg::PowBits-1:0]      pow_q;
  logic [dthf_pkg::MagBits-1:0]      mag_q;
  logic [3:0]                        dig_q [dthf_pkg::DigCount];
  logic                              ovalid_q;
  logic [dthf_pkg::CharBits-1:0]     ochar_q;
  logic                              olast_q;
  logic                              oinv_q;

  logic [dthf_pkg::ExpBits-1:0]      bexp;
  logic [dthf_pkg::FracBits-1:0]     bfrac;
  logic                              bzero;
  logic [dthf_pkg::PowBits-1:0]      pow_d;
  logic [3:0]                        cdig;
  logic [dthf_pkg::ProdBits-1:0]     csub;
  logic [dthf_pkg::ProdBits-1:0]     prod;
  logic [dthf_pkg::ProdBits-1:0]     pval;
  logic [3:0]                        nib;
  logic [dthf_pkg::CharBits-1:0]     ch;
  logic                              out_free;

  assign bexp  = in_bits_i[dthf_pkg::InBits-2 -: dthf_pkg::ExpBits];
  assign bfrac = in_bits_i[dthf_pkg::FracBits-1:0];
  assign bzero = (bexp == '0) && (bfrac == '0);

  always_comb begin
    if (bexp == '0) begin
      pow_d = bzero ? '0 : dthf_pkg::SubPow;
    end else begin
      pow_d = {1'b0, bexp} - {1'b0, dthf_pkg::ExpBias};
    end
  end

  always_comb begin
    pval = dthf_pkg::Place[cmd_i.conv_place];
    cdig = '0;
    csub = '0;
    prod = '0;
    for (int k = 1; k < 10; k++) begin
      prod = dthf_pkg::ProdBits'(pval * dthf_pkg::ProdBits'(k));
      if ({{(dthf_pkg::ProdBits-dthf_pkg::MagBits){1'b0}}, mag_q} >= prod) begin
        cdig = 4'(k);
        csub = prod;
      end
    end
  end

  assign nib = frac_q[dthf_pkg::FracBits-1 -: 4];

  always_comb begin
    case (cmd_i.sel)
      dthf_pkg::SEL_MINUS: ch = dthf_pkg::ChMinus;
      dthf_pkg::SEL_ZERO:  ch = dthf_pkg::ChZero;
      dthf_pkg::SEL_X:     ch = dthf_pkg::ChX;
      dthf_pkg::SEL_LEAD:  ch = zero_q ? dthf_pkg::ChZero : dthf_pkg::ChOne;
      dthf_pkg::SEL_DOT:   ch = dthf_pkg::ChDot;
      dthf_pkg::SEL_NIB: begin
        if (nib < 4'd10) begin
          ch = dthf_pkg::ChZero + {3'b0, nib};
        end else begin
          ch = dthf_pkg::ChHexA + {3'b0, nib};
        end
      end
      dthf_pkg::SEL_P:     ch = dthf_pkg::ChP;
      dthf_pkg::SEL_ESGN:  ch = pow_q[dthf_pkg::PowBits-1] ? dthf_pkg::ChMinus
                                                           : dthf_pkg::ChPlus;
      dthf_pkg::SEL_DIG:   ch = dthf_pkg::ChZero + {3'b0, dig_q[cmd_i.dig_idx]};
      dthf_pkg::SEL_NUL:   ch = dthf_pkg::ChNul;
      default:             ch = dthf_pkg::ChNul;
    endcase
  end

  assign out_free = !ovalid_q || out_ready_i;

  always_comb begin
    stat_o           = '0;
    stat_o.neg       = neg_q;
    stat_o.is_inf    = inf_q;
    stat_o.is_short  = short_q;
    stat_o.norm_done = frac_q[dthf_pkg::FracBits] || zero_q;
    stat_o.frac_nz   = (frac_q[dthf_pkg::FracBits-1:0] != '0);
    stat_o.nib_last  = (frac_q[dthf_pkg::FracBits-5:0] == '0);
    stat_o.out_free  = out_free;
    if (dig_q[3] != '0) begin
      stat_o.top_dig = 2'd3;
    end else if (dig_q[2] != '0) begin
      stat_o.top_dig = 2'd2;
    end else if (dig_q[1] != '0) begin
      stat_o.top_dig = 2'd1;
    end else begin
      stat_o.top_dig = 2'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      neg_q   <= in_bits_i[dthf_pkg::InBits-1];
      inf_q   <= (bexp == dthf_pkg::ExpOnes);
      zero_q  <= bzero;
      short_q <= bzero || ((bexp == dthf_pkg::ExpBias) && (bfrac == '0));
      frac_q  <= {(bexp != '0), bfrac};
      pow_q   <= pow_d;
    end else if (cmd_i.shift_norm) begin
      frac_q <= {frac_q[dthf_pkg::FracBits-1:0], 1'b0};
      pow_q  <= pow_q - 1'b1;
    end else if (cmd_i.emit && (cmd_i.sel == dthf_pkg::SEL_NIB)) begin
      frac_q <= {frac_q[dthf_pkg::FracBits], frac_q[dthf_pkg::FracBits-5:0], 4'b0};
    end
    if (cmd_i.mag_load) begin
      if (pow_q[dthf_pkg::PowBits-1]) begin
        mag_q <= dthf_pkg::MagBits'(-pow_q);
      end else begin
        mag_q <= pow_q[dthf_pkg::MagBits-1:0];
      end
    end else if (cmd_i.conv) begin
      mag_q                    <= mag_q - csub[dthf_pkg::MagBits-1:0];
      dig_q[cmd_i.conv_place]  <= cdig;
    end
    if (cmd_i.emit) begin
      ochar_q <= ch;
      olast_q <= cmd_i.last;
      oinv_q  <= cmd_i.invalid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      ovalid_q <= 1'b1;
    end else if (out_ready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  assign out_valid_o   = ovalid_q;
  assign out_char_o    = ochar_q;
  assign out_last_o    = olast_q;
  assign out_invalid_o = oinv_q;

endmodule

/* hw/rtl/double_to_hex_float_text_top.sv */
// Steps from the accepted word to its first character in the output register: decode,
// exponent digit conversion over four places, emit. Subnormals are first normalized one
// bit at a time (up to 52 bits). Infinity and NaN yield one NUL character after decode.
// A word gives n characters (6 to 24); output back-pressure stalls each one. The next word
// is taken once the last character has entered the output register.
// Reset: rst_ni clears the sequencer and the output valid only.
module double_to_hex_float_text_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // [63:0] value_bits
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [6:0] text_char, [7] zero
  output logic        m_axis_tlast_o,
  output logic        m_axis_tuser_o    // [0] invalid
);

  dthf_pkg::cmd_t                    cmd;
  dthf_pkg::stat_t                   stat;
  logic [dthf_pkg::CharBits-1:0]     out_char;

  dthf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  dthf_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_bits_i     (s_axis_tdata_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .out_char_o    (out_char),
    .out_last_o    (m_axis_tlast_o),
    .out_invalid_o (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {{(dthf_pkg::OutBytes-dthf_pkg::CharBits){1'b0}}, out_char};

endmodule
